/* rtl/core/rmst_pkg.sv */
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared constants, types and helpers for the range-minimum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

   localparam int LEAVES      = 1024;
   localparam int POS_W       = 11;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = $clog2(2 * LEAVES);
   localparam int STACK_DEPTH = $clog2(LEAVES) + 1;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);

   localparam logic [DATA_W-1:0] EMPTY_MIN = {1'b0, {(DATA_W-1){1'b1}}};

   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [DATA_W-1:0] word_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // node [lo, hi] sits at (lo + hi) | (lo != hi); the top slot folds onto 0
   function automatic addr_type slot_of(input pos_type lo, input pos_type hi);
      logic [POS_W:0] s;
      begin
         s = {1'b0, lo} + {1'b0, hi};
         s[0] = s[0] | (lo != hi);
         return s[ADDR_W-1:0];
      end
   endfunction

   function automatic pos_type mid_of(input pos_type lo, input pos_type hi);
      logic [POS_W:0] s;
      begin
         s = {1'b0, lo} + {1'b0, hi};
         return s[POS_W:1];
      end
   endfunction

   function automatic word_type smin(input word_type a, input word_type b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

endpackage

/* rtl/core/range_min_segment_tree.sv */
// ----------------------------------------------------------------------------
// range_min_segment_tree
// Segment tree over signed 32-bit values with point update and range minimum.
//
// Usage: the req_ channel carries one request, an update (action 0) or a
// query (action 1). A request is taken when req_valid is high and req_stall
// is low; req_stall stays high while a request is being worked. A query gives
// one response on the rsp_ channel, an update gives none. The csr_ channel
// writes leaf_count and is always ready; write it only while the block idles.
// All node words live in one single-port memory of 2 * LEAVES words, and one
// sequencer walks the tree with a small stack of pending nodes.
// Update: one step per level going down to the leaf, which is written, then a
// sibling read and a parent write per level going up; depth = ceil(log2 n).
// Query: the nodes are visited one at a time, up to about four per level.
// Reset: leaf_count returns to 1024 and a clearing pass writes 2147483647
// to all 2048 words, one per cycle; no request is taken during the pass.
// A stalled response holds in the output register; the next request may
// start meanwhile and waits at its end until the register is free.
// ----------------------------------------------------------------------------
module range_min_segment_tree
   import rmst_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_new_value,
   input  logic [POS_W-1:0]         req_range_lo,
   input  logic [POS_W-1:0]         req_range_hi,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_min_value,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [POS_W-1:0]         csr_leaf_count
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DOWN,
      S_UP,
      S_UPWR,
      S_VISIT,
      S_DRAIN
   } state_type;

   state_type   state_ff, state_in;
   pos_type     cur_lo_ff, cur_lo_in;
   pos_type     cur_hi_ff, cur_hi_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   pos_type     stk_lo_ff [STACK_DEPTH];
   pos_type     stk_hi_ff [STACK_DEPTH];
   pos_type     pos_ff, pos_in;
   word_type    val_ff, val_in;
   pos_type     qa_ff, qa_in;
   pos_type     qb_ff, qb_in;
   word_type    acc_ff, acc_in;
   logic        rd_pend_ff, rd_pend_in;
   addr_type    clr_ff, clr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_min_value_ff, rsp_min_value_in;
   pos_type     leaf_count_ff;
   word_type    rdata_ff;

   word_type    mem [2 * LEAVES];

   logic        mem_we;
   logic        mem_re;
   addr_type    mem_addr;
   word_type    mem_wdata;

   logic        push_en;
   pos_type     push_lo;
   pos_type     push_hi;

   pos_type     span;
   pos_type     mid;
   pos_type     top_lo;
   pos_type     top_hi;
   pos_type     top_mid;
   logic [SP_W-1:0] sp_dec;
   word_type    acc_fold;
   word_type    up_min;
   logic        out_free;

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_value_ff;
   assign csr_ready     = 1'b1;

   always_comb begin
      if (leaf_count_ff == '0) begin
         span = pos_type'(1);
      end else if (leaf_count_ff > pos_type'(LEAVES)) begin
         span = pos_type'(LEAVES);
      end else begin
         span = leaf_count_ff;
      end
   end

   assign mid      = mid_of(cur_lo_ff, cur_hi_ff);
   assign sp_dec   = sp_ff - 1'b1;
   assign top_lo   = stk_lo_ff[sp_dec[STK_AW-1:0]];
   assign top_hi   = stk_hi_ff[sp_dec[STK_AW-1:0]];
   assign top_mid  = mid_of(top_lo, top_hi);
   assign acc_fold = rd_pend_ff ? smin(acc_ff, rdata_ff) : acc_ff;
   assign up_min   = smin(val_ff, rdata_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      cur_lo_in        = cur_lo_ff;
      cur_hi_in        = cur_hi_ff;
      sp_in            = sp_ff;
      pos_in           = pos_ff;
      val_in           = val_ff;
      qa_in            = qa_ff;
      qb_in            = qb_ff;
      acc_in           = acc_fold;
      rd_pend_in       = 1'b0;
      clr_in           = clr_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_min_value_in = rsp_min_value_ff;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      mem_addr         = slot_of(cur_lo_ff, cur_hi_ff);
      mem_wdata        = val_ff;
      push_en          = 1'b0;
      push_lo          = cur_lo_ff;
      push_hi          = cur_hi_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = EMPTY_MIN;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cur_lo_in = pos_type'(1);
            cur_hi_in = span;
            sp_in     = '0;
            pos_in    = req_position;
            val_in    = req_new_value;
            qa_in     = req_range_lo;
            qb_in     = req_range_hi;
            acc_in    = EMPTY_MIN;
            if (req_valid) begin
               if (req_action == ACT_QUERY) begin
                  state_in = S_VISIT;
               end else if (req_position != '0 && req_position <= span) begin
                  state_in = S_DOWN;
               end
            end
         end
         S_DOWN: begin
            if (cur_lo_ff == cur_hi_ff) begin
               mem_we   = 1'b1;
               state_in = S_UP;
            end else begin
               push_en = 1'b1;
               sp_in   = sp_ff + 1'b1;
               if (pos_ff <= mid) begin
                  cur_hi_in = mid;
               end else begin
                  cur_lo_in = mid + 1'b1;
               end
            end
         end
         S_UP: begin
            if (sp_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               sp_in     = sp_dec;
               cur_lo_in = top_lo;
               cur_hi_in = top_hi;
               mem_re    = 1'b1;
               if (pos_ff <= top_mid) begin
                  mem_addr = slot_of(top_mid + 1'b1, top_hi);
               end else begin
                  mem_addr = slot_of(top_lo, top_mid);
               end
               state_in = S_UPWR;
            end
         end
         S_UPWR: begin
            mem_we    = 1'b1;
            mem_wdata = up_min;
            val_in    = up_min;
            state_in  = S_UP;
         end
         S_VISIT: begin
            if (qb_ff < cur_lo_ff || qa_ff > cur_hi_ff || qa_ff > qb_ff
                || (qa_ff <= cur_lo_ff && cur_hi_ff <= qb_ff)) begin
               if (!(qb_ff < cur_lo_ff || qa_ff > cur_hi_ff || qa_ff > qb_ff)) begin
                  mem_re     = 1'b1;
                  rd_pend_in = 1'b1;
               end
               if (sp_ff == '0) begin
                  state_in = S_DRAIN;
               end else begin
                  sp_in     = sp_dec;
                  cur_lo_in = top_lo;
                  cur_hi_in = top_hi;
               end
            end else begin
               push_en   = 1'b1;
               push_lo   = mid + 1'b1;
               push_hi   = cur_hi_ff;
               sp_in     = sp_ff + 1'b1;
               cur_hi_in = mid;
            end
         end
         S_DRAIN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_min_value_in = acc_fold;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         sp_ff         <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         leaf_count_ff <= pos_type'(LEAVES);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            leaf_count_ff <= csr_leaf_count;
         end
      end
      cur_lo_ff        <= cur_lo_in;
      cur_hi_ff        <= cur_hi_in;
      pos_ff           <= pos_in;
      val_ff           <= val_in;
      qa_ff            <= qa_in;
      qb_ff            <= qb_in;
      acc_ff           <= acc_in;
      rsp_min_value_ff <= rsp_min_value_in;
      if (push_en) begin
         stk_lo_ff[sp_ff[STK_AW-1:0]] <= push_lo;
         stk_hi_ff[sp_ff[STK_AW-1:0]] <= push_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

endmodule

/* tb/sv/range_min_segment_tree_tb.sv */
// ----------------------------------------------------------------------------
// range_min_segment_tree_tb
// Self-checking bench for the range-minimum segment tree. Point updates and
// range queries go in on the req_ channel while leaf_count is changed between
// phases. A behavioral tree model predicts each query response. Random gaps
// and stalls fall on both channels, and one long response hold-off backs the
// block up until it stalls its input.
// ----------------------------------------------------------------------------
module range_min_segment_tree_tb
   import rmst_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 132;

   logic     clock          = 1'b0;
   logic     reset          = 1'b1;
   logic     req_valid      = 1'b0;
   logic     req_stall;
   logic     req_action     = ACT_UPDATE;
   pos_type  req_position   = '0;
   logic signed [DATA_W-1:0] req_new_value = '0;
   pos_type  req_range_lo   = '0;
   pos_type  req_range_hi   = '0;
   logic     rsp_valid;
   logic     rsp_stall      = 1'b0;
   logic signed [DATA_W-1:0] rsp_min_value;
   logic     csr_valid      = 1'b0;
   logic     csr_ready;
   pos_type  csr_leaf_count = '0;

   word_type tree_words [0:2*LEAVES];
   pos_type  leaf_count_reg = pos_type'(LEAVES);
   word_type expected_minima [$];
   int       mismatch_count = 0;
   bit       sender_idle    = 1'b1;
   bit       receiver_idle  = 1'b1;
   bit       long_hold_due  = 1'b0;
   bit       long_hold_on   = 1'b0;

   range_min_segment_tree dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_position   (req_position),
      .req_new_value  (req_new_value),
      .req_range_lo   (req_range_lo),
      .req_range_hi   (req_range_hi),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_min_value  (rsp_min_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_leaf_count (csr_leaf_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- tree model
   function automatic int tree_extent();
      if (leaf_count_reg < 1) return 1;
      if (leaf_count_reg > LEAVES) return LEAVES;
      return int'(leaf_count_reg);
   endfunction

   function automatic int node_slot(int lo, int hi);
      return (lo + hi) | ((lo != hi) ? 1 : 0);
   endfunction

   function automatic word_type lesser_of(word_type a, word_type b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

   task automatic store_value(int pos, word_type value);
      int lo;
      int hi;
      int mid;
      int path_lo [$];
      int path_hi [$];
      lo = 1;
      hi = tree_extent();
      if (pos < lo || pos > hi) return;
      while (lo != hi) begin
         path_lo = {path_lo, lo};
         path_hi = {path_hi, hi};
         mid = (lo + hi) / 2;
         if (pos <= mid) hi = mid;
         else lo = mid + 1;
      end
      tree_words[node_slot(lo, hi)] = value;
      for (int i = path_lo.size() - 1; i >= 0; i--) begin
         lo  = path_lo[i];
         hi  = path_hi[i];
         mid = (lo + hi) / 2;
         tree_words[node_slot(lo, hi)] =
            lesser_of(tree_words[node_slot(lo, mid)], tree_words[node_slot(mid + 1, hi)]);
      end
   endtask

   function automatic word_type interval_min(int a, int b);
      word_type best;
      int       lo;
      int       hi;
      int       mid;
      int       open_lo [$];
      int       open_hi [$];
      best = EMPTY_MIN;
      open_lo = {open_lo, 1};
      open_hi = {open_hi, tree_extent()};
      while (open_lo.size() != 0) begin
         lo = open_lo.pop_back();
         hi = open_hi.pop_back();
         if (b < lo || a > hi || a > b) continue;
         if (a <= lo && hi <= b) begin
            best = lesser_of(best, tree_words[node_slot(lo, hi)]);
         end else begin
            mid = (lo + hi) / 2;
            open_lo = {open_lo, lo};
            open_hi = {open_hi, mid};
            open_lo = {open_lo, mid + 1};
            open_hi = {open_hi, hi};
         end
      end
      return best;
   endfunction

   // ------------------------------------------------------------------ helpers
   function automatic int pick_gap(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic word_type random_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h8000_0000;
      if (r == 1) return 32'h7FFF_FFFF;
      if (r < 4) return word_type'($urandom_range(0, 40) - 20);
      return $urandom;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_request(logic action, pos_type position, word_type value,
                               pos_type lo, pos_type hi);
      int gap;
      gap = pick_gap(sender_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= action;
      req_position  <= position;
      req_new_value <= value;
      req_range_lo  <= lo;
      req_range_hi  <= hi;
      do @(posedge clock); while (req_stall);
      if (action == ACT_UPDATE) store_value(int'(position), value);
      else expected_minima = {expected_minima, interval_min(int'(lo), int'(hi))};
   endtask

   task automatic send_update(pos_type position, word_type value);
      send_request(ACT_UPDATE, position, value, pos_type'($urandom), pos_type'($urandom));
   endtask

   task automatic send_query(pos_type lo, pos_type hi);
      send_request(ACT_QUERY, pos_type'($urandom), $urandom, lo, hi);
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      while (expected_minima.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_leaf_count(pos_type count);
      drain_requests();
      csr_valid      <= 1'b1;
      csr_leaf_count <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      leaf_count_reg = count;
   endtask

   task automatic send_random_request();
      int n;
      int r;
      int lo;
      int hi;
      n = tree_extent();
      if ($urandom_range(0, 1) == 0) begin
         if ($urandom_range(0, 99) < 85) send_update(pos_type'($urandom_range(1, n)), random_word());
         else send_update(pos_type'($urandom_range(0, 2047)), random_word());
         return;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         lo = $urandom_range(1, n);
         hi = $urandom_range(lo, n);
      end else if (r < 70) begin
         lo = $urandom_range(1, n);
         hi = lo;
      end else if (r < 78) begin
         lo = $urandom_range(0, n + 1);
         hi = $urandom_range(0, n + 1);
      end else if (r < 85) begin
         hi = $urandom_range(0, n - 1);
         lo = $urandom_range(hi + 1, n);
      end else if (r < 92) begin
         lo = ($urandom_range(0, 1) == 0) ? 1 : 0;
         hi = ($urandom_range(0, 1) == 0) ? n : n + 1;
      end else begin
         lo = $urandom_range(0, 2047);
         hi = $urandom_range(0, 2047);
      end
      send_query(pos_type'(lo), pos_type'(hi));
   endtask

   // ---------------------------------------------------------- response side
   initial begin
      int stall_len;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            long_hold_on  = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_on  = 1'b0;
         end else begin
            stall_len = pick_gap(receiver_idle);
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_minima.size() == 0) begin
            report_mismatch($sformatf("response %0d with no query outstanding",
                                      rsp_min_value));
         end else begin
            want = expected_minima.pop_front();
            if (word_type'(rsp_min_value) !== want)
               report_mismatch($sformatf("min_value expected %0d got %0d",
                                         $signed(want), rsp_min_value));
         end
      end
   end

   initial begin
      int stale_cycles = 0;
      while (stale_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            stale_cycles = 0;
         else
            stale_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // -------------------------------------------------------------------- tests
   task automatic test_directed_cases();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      send_query(11'd1, 11'd1024);
      send_query(11'd0, 11'd0);
      send_update(11'd1, 32'h8000_0000);
      send_update(11'd1024, 32'd5);
      send_update(11'd0, -32'sd5);
      send_update(11'd1025, -32'sd7);
      send_update(11'd2047, -32'sd9);
      send_update(11'd512, -32'sd1);
      send_query(11'd1, 11'd1024);
      send_query(11'd2, 11'd1024);
      send_query(11'd1024, 11'd1024);
      send_query(11'd1025, 11'd1025);
      send_query(11'd1000, 11'd1025);
      send_query(11'd600, 11'd500);
      send_query(11'd0, 11'd2047);
      send_update(11'd1, 32'h7FFF_FFFF);
      send_query(11'd1, 11'd1);
      send_query(11'd1, 11'd511);
      send_query(11'd2047, 11'd0);
      send_update(11'd513, 32'd0);
      send_query(11'd512, 11'd513);
   endtask

   task automatic test_random_sizes();
      int size_plan [12] = '{1, 0, 2, 3, 5, 17, 64, 1023, 1025, 2047, 300, 1024};
      for (int p = 0; p < 12; p++) begin
         write_leaf_count(pos_type'(size_plan[p]));
         sender_idle   = (p % 3 != 2);
         receiver_idle = (p % 4 != 1);
         repeat (PHASE_ITEMS) send_random_request();
      end
   endtask

   task automatic test_backpressure();
      write_leaf_count(pos_type'(LEAVES));
      sender_idle   = 1'b0;
      receiver_idle = 1'b1;
      long_hold_due = 1'b1;
      while (!long_hold_on) @(posedge clock);
      repeat (24) send_query(pos_type'($urandom_range(1, 512)),
                             pos_type'($urandom_range(512, 1024)));
      repeat (8) send_random_request();
   endtask

   initial begin
      for (int i = 0; i <= 2 * LEAVES; i++) tree_words[i] = EMPTY_MIN;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_sizes();
      test_backpressure();
      drain_requests();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
